/* rtl/stlu_pkg.sv */
// Shared types, codes and helpers of the symbol table lookup/insert core.
`default_nettype none

package stlu_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int NAME_CHARS_DEF    = 32;

   localparam logic [1:0] CMD_FIND        = 2'd0;
   localparam logic [1:0] CMD_ADD         = 2'd1;
   localparam logic [1:0] CMD_CLEAR_ALL   = 2'd2;
   localparam logic [1:0] CMD_CLEAR_LOCAL = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STATUS_EXISTS    = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd4;

   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  name_char;
      logic        name_last;
      logic [7:0]  id_type;
      logic [15:0] id_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  entry_index;
      logic [7:0]  entry_type;
      logic [15:0] entry_value;
      logic        entry_local;
   } rsp_type;

   typedef struct packed {
      logic        is_local;
      logic [7:0]  slot_type;
      logic [15:0] hash;
      logic [15:0] value;
   } meta_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // Fold ASCII a..z to A..Z.
   function automatic logic [7:0] fold_char(input logic [7:0] ch);
      logic [7:0] res;
      res = ch;
      if (ch inside {[8'h61:8'h7A]}) begin
         res = ch - 8'h20;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/stlu_char_cell.sv */
// One character cell of the pending-name shift chain with its byte compare.
`default_nettype none

module stlu_char_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire stlu_pkg::cell_ctl_type    ctl,
   input  wire logic [7:0]                prev_char,
   input  wire logic [7:0]                row_char,
   output logic [7:0]                     char_out,
   output logic                           match
);

   logic [7:0] cell_ff;
   logic [7:0] cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (ctl.clear) begin
         cell_in = '0;
      end else if (ctl.shift) begin
         cell_in = prev_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign char_out = cell_ff;
   assign match    = (cell_ff == row_char);

endmodule

`default_nettype wire

/* rtl/symbol_table_lookup_insert_core.sv */
// Top level of the hashed symbol table: name chain, slot memories and scan sequencer.
// A character that is not the last is taken and gives no result.
// A last character runs a scan of the slots (one slot read per cycle on the slot memory
// port, stopping at the first hit), then the result passes to the output register.
// Clear commands sweep the slot memory, then respond.
// Reset: synchronous; after it the block clears all slots with req_ready low;
// a bad name length or NUL character is answered at once.
`default_nettype none

module symbol_table_lookup_insert_core #(
   parameter int TABLE_ENTRIES = stlu_pkg::TABLE_ENTRIES_DEF,
   parameter int NAME_CHARS    = stlu_pkg::NAME_CHARS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire stlu_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output stlu_pkg::rsp_type       rsp_data
);

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int LEN_W  = $clog2(NAME_CHARS + 2);
   localparam int NAME_W = 8 * NAME_CHARS;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLR,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      addr_ff, addr_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  clr_all_ff, clr_all_in;
   logic                  is_add_ff, is_add_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [7:0]            add_type_ff, add_type_in;
   logic [15:0]           add_value_ff, add_value_in;
   logic [15:0]           hash_ff, hash_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  dot_ff, dot_in;
   logic                  nul_ff, nul_in;
   stlu_pkg::rsp_type     res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   stlu_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // Slot memories: metadata word and name row per slot.
   stlu_pkg::meta_type    meta_mem [TABLE_ENTRIES];
   logic [NAME_W-1:0]     name_mem [TABLE_ENTRIES];
   stlu_pkg::meta_type    meta_rd_ff;
   logic [NAME_W-1:0]     name_rd_ff;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic                  wr_name_en;
   logic [IDX_W-1:0]      wr_addr;
   stlu_pkg::meta_type    wr_meta;

   stlu_pkg::cell_ctl_type cell_ctl;
   logic [7:0]            ch;
   logic                  nul_next;
   logic [7:0]            cell_char [NAME_CHARS];
   logic [NAME_CHARS-1:0] cell_match;
   logic [NAME_W-1:0]     key_vec;
   logic                  name_eq;
   logic                  slot_used;
   logic [IDX_W+7:0]      hit_ext;
   logic [IDX_W+7:0]      free_ext;
   logic                  addr_done;

   assign ch        = stlu_pkg::fold_char(req_data.name_char);
   assign name_eq   = &cell_match;
   assign slot_used = (meta_rd_ff.slot_type != 8'd0);
   assign hit_ext   = {8'd0, rd_idx_ff};
   assign free_ext  = {8'd0, free_idx_ff};
   assign addr_done = (addr_ff == CNT_W'(TABLE_ENTRIES));

   // Pending-name chain: cell 0 takes the newest character, the rest shift along.
   // Stored rows use the same order, so equal rows mean equal names.
   for (genvar k = 0; k < NAME_CHARS; k++) begin : g_cell
      logic [7:0] prev;
      if (k == 0) begin : g_head
         assign prev = ch;
      end else begin : g_body
         assign prev = cell_char[k-1];
      end
      stlu_char_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .prev_char (prev),
         .row_char  (name_rd_ff[k*8 +: 8]),
         .char_out  (cell_char[k]),
         .match     (cell_match[k])
      );
      assign key_vec[k*8 +: 8] = cell_char[k];
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      rd_valid_in   = rd_valid_ff;
      rd_idx_in     = rd_idx_ff;
      clr_all_in    = clr_all_ff;
      is_add_in     = is_add_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      add_type_in   = add_type_ff;
      add_value_in  = add_value_ff;
      hash_in       = hash_ff;
      len_in        = len_ff;
      dot_in        = dot_ff;
      nul_in        = nul_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_name_en    = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_meta       = '0;
      cell_ctl      = '0;
      nul_next      = nul_ff | (ch == stlu_pkg::CHAR_NUL);

      // Drop the response once taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT, ST_CLR: begin
            // Read a slot, then clear it in the cycle after if it qualifies.
            if (!addr_done) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = addr_ff[IDX_W-1:0];
               addr_in     = addr_ff + CNT_W'(1);
            end else begin
               rd_valid_in = 1'b0;
            end
            if (rd_valid_ff && (clr_all_ff || meta_rd_ff.is_local)) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff;
               wr_meta = '0;
            end
            if (addr_done && !rd_valid_ff) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_RESP;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == stlu_pkg::CMD_CLEAR_ALL ||
                   req_data.cmd == stlu_pkg::CMD_CLEAR_LOCAL) begin
                  clr_all_in     = (req_data.cmd == stlu_pkg::CMD_CLEAR_ALL);
                  addr_in        = '0;
                  rd_valid_in    = 1'b0;
                  cell_ctl.clear = 1'b1;
                  hash_in        = '0;
                  len_in         = '0;
                  dot_in         = 1'b0;
                  nul_in         = 1'b0;
                  res_in         = '0;
                  res_in.status  = stlu_pkg::STATUS_OK;
                  state_in       = ST_CLR;
               end else begin
                  cell_ctl.shift = 1'b1;
                  nul_in         = nul_next;
                  hash_in        = hash_ff + {8'd0, ch};
                  if (len_ff == '0) begin
                     dot_in = (ch == stlu_pkg::CHAR_DOT);
                  end
                  if (len_ff <= LEN_W'(NAME_CHARS)) begin
                     len_in = len_ff + LEN_W'(1);
                  end
                  if (req_data.name_last) begin
                     if (nul_next || len_ff >= LEN_W'(NAME_CHARS)) begin
                        // Bad name: answer at once, table untouched.
                        cell_ctl.clear = 1'b1;
                        hash_in        = '0;
                        len_in         = '0;
                        dot_in         = 1'b0;
                        nul_in         = 1'b0;
                        res_in         = '0;
                        res_in.status  = stlu_pkg::STATUS_BAD_LEN;
                        state_in       = ST_RESP;
                     end else begin
                        is_add_in     = (req_data.cmd == stlu_pkg::CMD_ADD);
                        add_type_in   = req_data.id_type;
                        add_value_in  = req_data.id_value;
                        addr_in       = '0;
                        rd_valid_in   = 1'b0;
                        free_found_in = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
               end
            end
         end
         ST_SCAN: begin
            if (!addr_done) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = addr_ff[IDX_W-1:0];
               addr_in     = addr_ff + CNT_W'(1);
            end else begin
               rd_valid_in = 1'b0;
            end
            if (rd_valid_ff) begin
               if (slot_used && meta_rd_ff.hash == hash_ff && name_eq) begin
                  // First match: report it and stop.
                  res_in.status      = is_add_ff ? stlu_pkg::STATUS_EXISTS
                                                 : stlu_pkg::STATUS_OK;
                  res_in.entry_index = hit_ext[7:0];
                  res_in.entry_type  = meta_rd_ff.slot_type;
                  res_in.entry_value = meta_rd_ff.value;
                  res_in.entry_local = meta_rd_ff.is_local;
                  rd_valid_in        = 1'b0;
                  cell_ctl.clear     = 1'b1;
                  hash_in            = '0;
                  len_in             = '0;
                  dot_in             = 1'b0;
                  nul_in             = 1'b0;
                  state_in           = ST_RESP;
               end else if (!slot_used && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
            end else if (addr_done) begin
               res_in = '0;
               if (!is_add_ff) begin
                  res_in.status = stlu_pkg::STATUS_NOT_FOUND;
               end else if (free_found_ff) begin
                  wr_en              = 1'b1;
                  wr_name_en         = 1'b1;
                  wr_addr            = free_idx_ff;
                  wr_meta.is_local   = dot_ff;
                  wr_meta.slot_type  = add_type_ff;
                  wr_meta.hash       = hash_ff;
                  wr_meta.value      = add_value_ff;
                  res_in.status      = stlu_pkg::STATUS_OK;
                  res_in.entry_index = free_ext[7:0];
                  res_in.entry_type  = add_type_ff;
                  res_in.entry_value = add_value_ff;
                  res_in.entry_local = dot_ff;
               end else begin
                  res_in.status = stlu_pkg::STATUS_FULL;
               end
               cell_ctl.clear = 1'b1;
               hash_in        = '0;
               len_in         = '0;
               dot_in         = 1'b0;
               nul_in         = 1'b0;
               state_in       = ST_RESP;
            end
         end
         ST_RESP: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         addr_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         clr_all_ff    <= 1'b1;
         free_found_ff <= 1'b0;
         hash_ff       <= '0;
         len_ff        <= '0;
         dot_ff        <= 1'b0;
         nul_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         rd_valid_ff   <= rd_valid_in;
         clr_all_ff    <= clr_all_in;
         free_found_ff <= free_found_in;
         hash_ff       <= hash_in;
         len_ff        <= len_in;
         dot_ff        <= dot_in;
         nul_ff        <= nul_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_idx_ff     <= rd_idx_in;
         is_add_ff     <= is_add_in;
         free_idx_ff   <= free_idx_in;
         add_type_ff   <= add_type_in;
         add_value_ff  <= add_value_in;
         res_ff        <= res_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         meta_mem[wr_addr] <= wr_meta;
      end
      if (wr_name_en) begin
         name_mem[wr_addr] <= key_vec;
      end
      if (rd_en) begin
         meta_rd_ff <= meta_mem[rd_addr];
         name_rd_ff <= name_mem[rd_addr];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_CLR || state_ff == ST_INIT))
      else $error("slot write outside scan or sweep");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response loaded outside response state");

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("sweep address past table end");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_valid_ff)
      else $error("stale slot read in idle");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(NAME_CHARS + 1))
      else $error("name length counter overrun");
`endif

endmodule

`default_nettype wire
